// ===== rtl/tmfl_pkg.sv =====
// Shared widths, status codes and defaults for the tagged message field lookup.
package tmfl_pkg;

    localparam int WORD_W   = 32;
    localparam int INDEX_W  = 8;
    localparam int BYTES_W  = 11;
    localparam int SSTART_W = 9;
    localparam int STATUS_W = 2;

    localparam int MESSAGE_WORDS_DEF = 256;

    localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MALFORMED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // Store write port, grouped for the hop into the word store.
    typedef struct packed {
        logic              we;
        logic [WORD_W-1:0] data;
    } t_store_wr;

endpackage

// ===== rtl/tmfl_channels.sv =====
// Valid/ready channel interfaces for command words and result words.
interface tmfl_cmd_if;
    logic                         valid;
    logic                         ready;
    logic                         command;
    logic [tmfl_pkg::INDEX_W-1:0] write_index;
    logic [tmfl_pkg::WORD_W-1:0]  write_word;
    logic [tmfl_pkg::INDEX_W-1:0] region_start;
    logic [tmfl_pkg::BYTES_W-1:0] region_bytes;
    logic [tmfl_pkg::WORD_W-1:0]  search_tag;

    modport source (
        output valid, command, write_index, write_word, region_start,
               region_bytes, search_tag,
        input  ready
    );
    modport sink (
        input  valid, command, write_index, write_word, region_start,
               region_bytes, search_tag,
        output ready
    );
endinterface

interface tmfl_res_if;
    logic                          valid;
    logic                          ready;
    logic [tmfl_pkg::STATUS_W-1:0] status;
    logic [tmfl_pkg::SSTART_W-1:0] slice_start;
    logic [tmfl_pkg::BYTES_W-1:0]  slice_bytes;

    modport source (
        output valid, status, slice_start, slice_bytes,
        input  ready
    );
    modport sink (
        input  valid, status, slice_start, slice_bytes,
        output ready
    );
endinterface

// ===== rtl/tagged_message_field_lookup.sv =====
// Top level: message store plus tag search sequencer.
//
//   channel   dir  handshake     payload
//   i_cmd     in   valid/ready   command, write_index, write_word, region_start,
//                                region_bytes, search_tag
//   o_res     out  valid/ready   status, slice_start, slice_bytes
//
// A write word gives no result.
// A lookup checks the region, reads the tag count from the header, scans the
// tag words in turn, then reads the offsets and forms the slice; the single
// store read port sets the pace.
// i_rst_n is synchronous; store contents are not cleared.
// The block takes no command while a lookup runs or its result waits.
module tagged_message_field_lookup #(
    parameter int MESSAGE_WORDS = tmfl_pkg::MESSAGE_WORDS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tmfl_cmd_if.sink   i_cmd,
    tmfl_res_if.source o_res
);

    localparam int AW = $clog2(MESSAGE_WORDS);
    localparam logic [12:0] DEPTH_L = 13'(MESSAGE_WORDS);
    localparam logic [14:0] LIMIT_B = 15'(MESSAGE_WORDS * 4);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_CHECK = 9'b000000010,
        S_HDR   = 9'b000000100,
        S_TAG   = 9'b000001000,
        S_OFF   = 9'b000010000,
        S_END   = 9'b000100000,
        S_CALC  = 9'b001000000,
        S_FIN   = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    logic [tmfl_pkg::INDEX_W-1:0]  r_start, n_start;
    logic [tmfl_pkg::BYTES_W-1:0]  r_bytes, n_bytes;
    logic [tmfl_pkg::WORD_W-1:0]   r_want, n_want;
    logic [8:0]                    r_n, n_n;
    logic [8:0]                    r_i, n_i;
    logic [tmfl_pkg::WORD_W-1:0]   r_off, n_off;
    logic [tmfl_pkg::WORD_W-1:0]   r_end, n_end;
    logic [tmfl_pkg::WORD_W-1:0]   r_ow, n_ow;
    logic [tmfl_pkg::WORD_W-1:0]   r_len, n_len;
    logic [tmfl_pkg::STATUS_W-1:0] r_status, n_status;
    logic [tmfl_pkg::SSTART_W-1:0] r_sstart, n_sstart;
    logic [tmfl_pkg::BYTES_W-1:0]  r_sbytes, n_sbytes;

    logic                        w_accept;
    tmfl_pkg::t_store_wr         w_wr;
    logic [AW-1:0]               w_waddr;
    logic [AW-1:0]               w_raddr;
    logic [tmfl_pkg::WORD_W-1:0] w_rdata;
    logic [9:0]                  w_k;
    logic [9:0]                  w_inext;
    logic [8:0]                  w_words;
    logic [14:0]                 w_span;
    logic [33:0]                 w_send;

    assign w_accept = i_cmd.valid && i_cmd.ready;
    assign i_cmd.ready = (r_state == S_IDLE);

    // Drop writes beyond the store end.
    assign w_wr.we   = w_accept && (i_cmd.command == tmfl_pkg::CMD_WRITE)
                       && (13'(i_cmd.write_index) < DEPTH_L);
    assign w_wr.data = i_cmd.write_word;
    assign w_waddr   = AW'(i_cmd.write_index);

    assign w_words = r_bytes[10:2];
    assign w_inext = 10'(r_i) + 10'd1;
    assign w_span  = 15'({r_start, 2'b00}) + 15'(r_bytes);
    assign w_send  = {r_ow, 2'b00} + 34'(r_len);
    assign w_raddr = AW'(12'(r_start) + 12'(w_k));

    tmfl_store #(
        .DEPTH (MESSAGE_WORDS),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_wr    (w_wr),
        .i_waddr (w_waddr),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state  = r_state;
        n_start  = r_start;
        n_bytes  = r_bytes;
        n_want   = r_want;
        n_n      = r_n;
        n_i      = r_i;
        n_off    = r_off;
        n_end    = r_end;
        n_ow     = r_ow;
        n_len    = r_len;
        n_status = r_status;
        n_sstart = r_sstart;
        n_sbytes = r_sbytes;
        w_k      = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && (i_cmd.command == tmfl_pkg::CMD_LOOKUP)) begin
                    n_start = i_cmd.region_start;
                    n_bytes = i_cmd.region_bytes;
                    n_want  = i_cmd.search_tag;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_sstart = '0;
                n_sbytes = '0;
                if (r_bytes[1:0] != 2'b00 || w_span > LIMIT_B || w_words == '0) begin
                    n_status = tmfl_pkg::ST_MALFORMED;
                    n_state  = S_OUT;
                end else begin
                    // Fetch the tag count.
                    w_k     = '0;
                    n_state = S_HDR;
                end
            end
            S_HDR: begin
                if (w_rdata == '0) begin
                    n_status = tmfl_pkg::ST_NOT_FOUND;
                    n_state  = S_OUT;
                end else if (w_rdata >= 32'(w_words)) begin
                    n_status = tmfl_pkg::ST_MALFORMED;
                    n_state  = S_OUT;
                end else begin
                    n_n     = w_rdata[8:0];
                    n_i     = '0;
                    w_k     = 10'(w_rdata[8:0]);
                    n_state = S_TAG;
                end
            end
            S_TAG: begin
                if (w_rdata == r_want) begin
                    w_k     = 10'(r_i);
                    n_state = S_OFF;
                end else if (w_inext == 10'(r_n)) begin
                    n_status = tmfl_pkg::ST_NOT_FOUND;
                    n_state  = S_OUT;
                end else if (w_inext + 10'(r_n) >= 10'(w_words)) begin
                    // Next tag word lies past the region end.
                    n_status = tmfl_pkg::ST_MALFORMED;
                    n_state  = S_OUT;
                end else begin
                    n_i = w_inext[8:0];
                    w_k = w_inext + 10'(r_n);
                end
            end
            S_OFF: begin
                n_off = (r_i == '0) ? '0 : w_rdata;
                if (w_inext == 10'(r_n)) begin
                    // Last tag: value runs to the region end.
                    n_end   = 32'(r_bytes) - 32'({r_n, 3'b000});
                    n_state = S_CALC;
                end else begin
                    w_k     = w_inext;
                    n_state = S_END;
                end
            end
            S_END: begin
                n_end   = w_rdata;
                n_state = S_CALC;
            end
            S_CALC: begin
                n_ow    = 32'({r_n, 1'b0}) + {2'b00, r_off[31:2]};
                n_len   = r_end - r_off;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (w_send > 34'(r_bytes)) begin
                    n_status = tmfl_pkg::ST_MALFORMED;
                end else begin
                    n_status = tmfl_pkg::ST_FOUND;
                    n_sstart = {1'b0, r_start} + r_ow[8:0];
                    n_sbytes = r_len[10:0];
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (o_res.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_start  <= n_start;
        r_bytes  <= n_bytes;
        r_want   <= n_want;
        r_n      <= n_n;
        r_i      <= n_i;
        r_off    <= n_off;
        r_end    <= n_end;
        r_ow     <= n_ow;
        r_len    <= n_len;
        r_status <= n_status;
        r_sstart <= n_sstart;
        r_sbytes <= n_sbytes;
    end

    assign o_res.valid       = (r_state == S_OUT);
    assign o_res.status      = r_status;
    assign o_res.slice_start = r_sstart;
    assign o_res.slice_bytes = r_sbytes;

`ifndef ASSERT_OFF
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && r_status != tmfl_pkg::ST_FOUND)
            |-> (r_sstart == '0 && r_sbytes == '0))
        else $error("failed lookup carries a nonzero slice");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> !i_cmd.ready)
        else $error("command taken while a result waits");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TAG) |-> (r_i < r_n && r_n < w_words))
        else $error("tag scan outside the header");

    a_slice_in_region: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && r_status == tmfl_pkg::ST_FOUND)
            |-> (r_sbytes <= r_bytes))
        else $error("found slice longer than its region");

    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_cmd.command == tmfl_pkg::CMD_WRITE)
            |=> (i_cmd.ready && !o_res.valid))
        else $error("write word did not return to idle");
`endif

endmodule

// ===== rtl/tmfl_store.sv =====
// Message word store: one write port, one read port with registered data.
module tmfl_store #(
    parameter int DEPTH = tmfl_pkg::MESSAGE_WORDS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                        i_clk,
    input  tmfl_pkg::t_store_wr         i_wr,
    input  logic [AW-1:0]               i_waddr,
    input  logic [AW-1:0]               i_raddr,
    output logic [tmfl_pkg::WORD_W-1:0] o_rdata
);

    logic [tmfl_pkg::WORD_W-1:0] r_mem [DEPTH];
    logic [tmfl_pkg::WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_waddr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
